FILE: design/pli_pkg.sv
// Shared constants, status codes and the cell command type for the positional list.
`timescale 1ns / 1ps
package pli_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;
   localparam int LEN_W    = 5;
   localparam int STAT_W   = 2;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [STAT_W-1:0] ST_DONE  = STAT_W'(0);
   localparam logic [STAT_W-1:0] ST_RANGE = STAT_W'(1);
   localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [CMP_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

FILE: design/positional_list_insert_remove.sv
// Top level: positional list as a row of shifting cells with a length counter.
//
//   channel  dir  fields                                       handshake
//   req_     in   kind, position, value                        req_valid / req_stall
//   rsp_     out  status, removed_value, list_length           rsp_valid / rsp_stall
//
// One operation per cycle while req_stall is low: every cell compares its index with
// the position and shifts at the accepting edge, which also loads the result beat into
// the output register; the result is offered from the next cycle.
// A new beat is taken while the held result is being taken; req_stall follows rsp_stall
// only while a result is held. Synchronous reset empties the list and clears rsp_valid.
`timescale 1ns / 1ps
module positional_list_insert_remove (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [pli_pkg::POS_W-1:0]     req_position,
   input  logic [pli_pkg::DATA_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pli_pkg::STAT_W-1:0]    rsp_status,
   output logic [pli_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic [pli_pkg::LEN_W-1:0]     rsp_list_length
);
   import pli_pkg::*;

   logic                 accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [STAT_W-1:0]    status_ff;
   logic [STAT_W-1:0]    status_in;
   logic [DATA_W-1:0]    removed_ff;
   logic [DATA_W-1:0]    removed_in;
   logic [CMP_W-1:0]     pos;
   logic [CMP_W-1:0]     cnt;
   cell_cmd_type         cmd;
   logic [DATA_W-1:0]    cell_data [CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pos       = CMP_W'(req_position);
   assign cnt       = CMP_W'(count_ff);

   always_comb begin
      cmd.ins    = 1'b0;
      cmd.rem    = 1'b0;
      cmd.pos    = pos;
      cmd.value  = req_value;
      status_in  = ST_DONE;
      removed_in = '0;
      count_in   = count_ff;
      if (req_kind == KIND_INSERT) begin
         if (pos > cnt) begin
            status_in = ST_RANGE;
         end else if (cnt >= CMP_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            cmd.ins  = accept;
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (pos >= cnt) begin
            status_in = ST_RANGE;
         end else begin
            cmd.rem    = accept;
            removed_in = cell_data[req_position[IDX_W-1:0]];
            count_in   = count_ff - CNT_W'(1);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [DATA_W-1:0] left_w;
         logic [DATA_W-1:0] right_w;
         if (g == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = cell_data[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_right
            assign right_w = cell_data[g+1];
         end
         pli_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .idx        (IDX_W'(g)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_list_length   = LEN_W'(count_ff);

endmodule

FILE: design/pli_cell.sv
// One list slot: holds a word and shifts from a neighbour on insert or remove, or loads the inserted value.
`timescale 1ns / 1ps
module pli_cell (
   input  logic                        clock,
   input  pli_pkg::cell_cmd_type       cmd,
   input  logic [pli_pkg::IDX_W-1:0]   idx,
   input  logic [pli_pkg::DATA_W-1:0]  left_data,
   input  logic [pli_pkg::DATA_W-1:0]  right_data,
   output logic [pli_pkg::DATA_W-1:0]  data
);
   import pli_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [CMP_W-1:0]  my_idx;

   assign my_idx = CMP_W'(idx);

   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (my_idx > cmd.pos) begin
            data_in = left_data;
         end else if (my_idx == cmd.pos) begin
            data_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (my_idx >= cmd.pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: tb/list_checker.sv
// Checker for the positional list: predicts each result beat from accepted requests and compares.
`timescale 1ns / 1ps
module list_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_kind,
   input  logic [pli_pkg::POS_W-1:0]  req_position,
   input  logic [pli_pkg::DATA_W-1:0] req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [pli_pkg::STAT_W-1:0] rsp_status,
   input  logic [pli_pkg::DATA_W-1:0] rsp_removed_value,
   input  logic [pli_pkg::LEN_W-1:0]  rsp_list_length,
   output int                         fail_count,
   output int                         pending
);
   import pli_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] removed;
      logic [LEN_W-1:0]  length;
   } list_result_type;

   logic [DATA_W-1:0] list_words [CAPACITY];
   int                list_len;
   list_result_type   awaited_results [$];
   list_result_type   want;

   initial begin
      fail_count = 0;
      pending    = 0;
      list_len   = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic list_result_type apply_list_op(input logic kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] val);
      list_result_type r;
      int              p;
      r        = '0;
      r.status = ST_DONE;
      p        = int'(pos);
      if (kind == KIND_INSERT) begin
         if (p > list_len) begin
            r.status = ST_RANGE;
         end else if (list_len >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            for (int i = list_len; i > p; i--) list_words[i] = list_words[i-1];
            list_words[p] = val;
            list_len++;
         end
      end else begin
         if (p >= list_len) begin
            r.status = ST_RANGE;
         end else begin
            r.removed = list_words[p];
            for (int i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
            list_len--;
         end
      end
      r.length = LEN_W'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat: status %0d removed %h length %0d",
                                         rsp_status, rsp_removed_value, rsp_list_length));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, want.status));
               if (rsp_removed_value !== want.removed)
                  report_mismatch($sformatf("removed_value got %h expected %h",
                                            rsp_removed_value, want.removed));
               if (rsp_list_length !== want.length)
                  report_mismatch($sformatf("list_length got %0d expected %0d",
                                            rsp_list_length, want.length));
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(apply_list_op(req_kind, req_position, req_value));
      end
      pending = awaited_results.size();
   end

endmodule

FILE: tb/tb_top.sv
// Testbench top: clock, reset, insert/remove stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
   import pli_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 10;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = KIND_INSERT;
   logic [POS_W-1:0]  req_position = '0;
   logic [DATA_W-1:0] req_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [DATA_W-1:0] rsp_removed_value;
   logic [LEN_W-1:0]  rsp_list_length;

   int fail_count;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int shadow_len = 0;
   int quiet_cycles = 0;
   bit pressure_go = 1'b0;
   bit pressure_hold = 1'b0;
   bit grow = 1'b1;

   positional_list_insert_remove uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_list_length   (rsp_list_length)
   );

   list_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_list_length   (rsp_list_length),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      forever @(negedge clock) rsp_stall <= pressure_hold || ($urandom_range(0, 99) < stall_pct);
   end

   // long receiver hold-off so a result is held and the block stalls its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      pressure_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      pressure_hold = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic issue(input logic kind, input logic [POS_W-1:0] pos,
                        input logic [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_INSERT && int'(pos) <= shadow_len && shadow_len < CAPACITY)
         shadow_len++;
      else if (kind == KIND_REMOVE && int'(pos) < shadow_len)
         shadow_len--;
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return $urandom();
   endfunction

   task automatic random_beat();
      logic             kind;
      logic [POS_W-1:0] pos;
      if (shadow_len == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      if (shadow_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      if ($urandom_range(0, 99) < 12) begin
         kind = 1'($urandom_range(0, 1));
         pos  = POS_W'($urandom_range(0, CAPACITY));
      end else begin
         if ($urandom_range(0, 99) < (grow ? 75 : 25)) kind = KIND_INSERT;
         else kind = KIND_REMOVE;
         if (kind == KIND_INSERT)
            pos = POS_W'($urandom_range(0, shadow_len));
         else if (shadow_len == 0)
            pos = '0;
         else
            pos = POS_W'($urandom_range(0, shadow_len - 1));
      end
      issue(kind, pos, pick_word());
   endtask

   task automatic run_phase(input int beats, input int idle, input int stall,
                            input int hold_at);
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < beats; i++) begin
         if (i == hold_at) pressure_go = 1'b1;
         random_beat();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty-list and past-the-end errors, then front, middle and end inserts, and end and front removes
      issue(KIND_REMOVE, 0, 32'hDEAD_BEEF);
      issue(KIND_INSERT, 1, 32'h1234_5678);
      issue(KIND_INSERT, 0, 32'hFFFF_FFFF);
      issue(KIND_INSERT, 1, 32'h0000_0000);
      issue(KIND_INSERT, 0, 32'hA5A5_A5A5);
      issue(KIND_INSERT, 1, 32'h5A5A_5A5A);
      issue(KIND_REMOVE, 3, 32'hFFFF_FFFF);
      issue(KIND_REMOVE, 3, 32'h0);
      issue(KIND_REMOVE, 0, 32'h0);
      for (int i = 0; i < 14; i++)
         issue(KIND_INSERT, (i == 13) ? POS_W'(15) : POS_W'((i * 7) % (shadow_len + 1)),
               $urandom());
      // full list: insert at the end and at the front, remove past the end, remove last
      issue(KIND_INSERT, 16, 32'hFFFF_FFFF);
      issue(KIND_INSERT, 0, 32'h0);
      issue(KIND_REMOVE, 16, 32'h0);
      issue(KIND_REMOVE, 15, 32'h0);

      run_phase(125, 0, 0, 20);
      run_phase(125, 63, 0, -1);
      run_phase(125, 0, 63, -1);
      run_phase(125, 19, 19, -1);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: positional_list_insert_remove.f
design/pli_pkg.sv
design/pli_cell.sv
design/positional_list_insert_remove.sv
tb/list_checker.sv
tb/tb_top.sv
